>>> rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
// Used by the controller, the datapath, the top level and the checker.
package lobm_pkg;

    localparam int BOOK_DEPTH  = 32;
    localparam int IDX_W       = $clog2(BOOK_DEPTH);
    localparam int CNT_W       = $clog2(BOOK_DEPTH + 1);
    localparam int MAX_RESULTS = 32;
    localparam int NTR_W       = $clog2(MAX_RESULTS + 1);

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;
    localparam logic SIDE_BID  = 1'b0;
    localparam logic SIDE_ASK  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        ST_TRADE     = 3'd0,
        ST_RESTED    = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_BEST,
        MODE_CANCEL,
        MODE_OUTER,
        MODE_INNER
    } mode_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_CANCEL_SCAN,
        S_CANCEL_DONE,
        S_BEST_SCAN,
        S_BEST_DONE,
        S_OUTER_RD,
        S_OUTER_EV,
        S_INNER_SCAN,
        S_OUTER_NEXT,
        S_PAIR_DONE,
        S_EMIT_PEND,
        S_TRADE,
        S_WB_BID,
        S_WB_ASK,
        S_EMIT_FINAL
    } state_t;

    typedef struct packed {
        logic        side;
        logic [19:0] price;
        logic [23:0] qty;
        logic [31:0] oid;
        logic [15:0] instr;
        logic [31:0] mkt;
        logic [23:0] cur;
        logic [31:0] arrival;
    } slot_t;

    typedef struct packed {
        logic    load;
        logic    insert;
        logic    rd_en;
        idx_t    rd_addr;
        mode_t   mode;
        logic    clr_best;
        logic    clr_pick;
        logic    clr_pair;
        logic    cancel_clr;
        logic    trade;
        logic    wb_bid;
        logic    wb_ask;
        logic    push;
        logic    push_pend;
        logic    push_last;
        status_t push_code;
    } cmd_t;

    typedef struct packed {
        logic opcode;
        logic qty_zero;
        logic full;
        logic pick_found;
        logic best_ok;
        logic hold_cand;
        logic pair_found;
        logic pend_vld;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/limit_order_book_matcher_core.sv
// Channel | handshake            | payload
// input   | in_valid / in_stall  | opcode side order_id instrument market_code
//         |                      | currency_code limit_price order_quantity
// output  | out_valid/ out_stall | status trade_id buy_order_id sell_order_id trade_market
//         |                      | trade_currency trade_price trade_quantity last
//
// One transaction at a time through a single-port slot memory, one slot per cycle.
// Cancel: a scan of all slots for the order, then its status result. Add: after the insert,
// per match round, a best-price scan and, when the best levels cross, a bid pass over
// all slots with an ask scan for each bid at the best level; a trade then writes back bid
// and ask, after any waiting trade result has gone out. Full book or zero quantity: status only.
// Reset frees all slots at once by clearing their valid bits; no clearing pass. A stalled result holds the engine.
// Top level of the order book matcher; depends on lobm_pkg, lobm_ctrl, lobm_dp.
module limit_order_book_matcher_core
    import lobm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic        side,
    input  logic [31:0] order_id,
    input  logic [15:0] instrument,
    input  logic [31:0] market_code,
    input  logic [23:0] currency_code,
    input  logic [19:0] limit_price,
    input  logic [23:0] order_quantity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] trade_id,
    output logic [31:0] buy_order_id,
    output logic [31:0] sell_order_id,
    output logic [31:0] trade_market,
    output logic [23:0] trade_currency,
    output logic [19:0] trade_price,
    output logic [23:0] trade_quantity,
    output logic        last
);

    cmd_t  cmd;
    stat_t st;

    lobm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    lobm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .opcode         (opcode),
        .side           (side),
        .order_id       (order_id),
        .instrument     (instrument),
        .market_code    (market_code),
        .currency_code  (currency_code),
        .limit_price    (limit_price),
        .order_quantity (order_quantity),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .trade_id       (trade_id),
        .buy_order_id   (buy_order_id),
        .sell_order_id  (sell_order_id),
        .trade_market   (trade_market),
        .trade_currency (trade_currency),
        .trade_price    (trade_price),
        .trade_quantity (trade_quantity),
        .last           (last)
    );

endmodule

>>> rtl/lobm_ctrl.sv
// Sequencer of the order book matcher: scans, match rounds and result pushes.
// Depends on lobm_pkg; drives the datapath through cmd_t, reads stat_t.
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] outer_reg, outer_next;
    logic [NTR_W-1:0] ntr_reg, ntr_next;
    status_t          fin_code_reg, fin_code_next;
    logic             fin_pend_reg, fin_pend_next;
    logic             scan_end;

    assign scan_end = (cnt_reg == CNT_W'(BOOK_DEPTH));
    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            outer_reg    <= '0;
            ntr_reg      <= '0;
            fin_code_reg <= ST_RESTED;
            fin_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            outer_reg    <= outer_next;
            ntr_reg      <= ntr_next;
            fin_code_reg <= fin_code_next;
            fin_pend_reg <= fin_pend_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        outer_next    = outer_reg;
        ntr_next      = ntr_reg;
        fin_code_next = fin_code_reg;
        fin_pend_next = fin_pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                cnt_next      = '0;
                ntr_next      = '0;
                fin_pend_next = 1'b0;
                if (st.opcode == OP_CANCEL)
                    state_next = S_CANCEL_SCAN;
                else if (st.full)
                begin
                    fin_code_next = ST_FULL;
                    state_next    = S_EMIT_FINAL;
                end
                else if (st.qty_zero)
                begin
                    fin_code_next = ST_RESTED;
                    state_next    = S_EMIT_FINAL;
                end
                else
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cnt_next   = '0;
                state_next = S_BEST_SCAN;
            end
            S_CANCEL_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                    state_next = S_CANCEL_DONE;
            end
            S_CANCEL_DONE:
            begin
                fin_code_next = st.pick_found ? ST_CANCELLED : ST_NOT_FOUND;
                fin_pend_next = 1'b0;
                state_next    = S_EMIT_FINAL;
            end
            S_BEST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                    state_next = S_BEST_DONE;
            end
            S_BEST_DONE:
            begin
                outer_next = '0;
                if (st.best_ok)
                    state_next = S_OUTER_RD;
                else
                begin
                    fin_code_next = ST_RESTED;
                    fin_pend_next = st.pend_vld;
                    state_next    = S_EMIT_FINAL;
                end
            end
            S_OUTER_RD:
                state_next = S_OUTER_EV;
            S_OUTER_EV:
            begin
                cnt_next = '0;
                if (st.hold_cand)
                    state_next = S_INNER_SCAN;
                else
                    state_next = S_OUTER_NEXT;
            end
            S_INNER_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                    state_next = S_OUTER_NEXT;
            end
            S_OUTER_NEXT:
            begin
                if (outer_reg == CNT_W'(BOOK_DEPTH - 1))
                    state_next = S_PAIR_DONE;
                else
                begin
                    outer_next = outer_reg + 1'b1;
                    state_next = S_OUTER_RD;
                end
            end
            S_PAIR_DONE:
            begin
                if (!st.pair_found)
                begin
                    fin_code_next = ST_RESTED;
                    fin_pend_next = st.pend_vld;
                    state_next    = S_EMIT_FINAL;
                end
                else if (st.pend_vld)
                    state_next = S_EMIT_PEND;
                else
                    state_next = S_TRADE;
            end
            S_EMIT_PEND:
            begin
                if (st.out_free)
                    state_next = S_TRADE;
            end
            S_TRADE:
            begin
                ntr_next   = ntr_reg + 1'b1;
                state_next = S_WB_BID;
            end
            S_WB_BID:
                state_next = S_WB_ASK;
            S_WB_ASK:
            begin
                cnt_next = '0;
                if (ntr_reg == NTR_W'(MAX_RESULTS))
                begin
                    fin_pend_next = 1'b1;
                    state_next    = S_EMIT_FINAL;
                end
                else
                    state_next = S_BEST_SCAN;
            end
            S_EMIT_FINAL:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.mode      = MODE_BEST;
        cmd.push_code = ST_RESTED;
        cmd.rd_addr   = cnt_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
                cmd.load = in_valid;
            S_INSERT:
                cmd.insert = 1'b1;
            S_CANCEL_SCAN:
            begin
                cmd.mode     = MODE_CANCEL;
                cmd.rd_en    = !scan_end;
                cmd.clr_pick = (cnt_reg == '0);
            end
            S_CANCEL_DONE:
                cmd.cancel_clr = 1'b1;
            S_BEST_SCAN:
            begin
                cmd.mode     = MODE_BEST;
                cmd.rd_en    = !scan_end;
                cmd.clr_best = (cnt_reg == '0);
            end
            S_BEST_DONE:
                cmd.clr_pair = 1'b1;
            S_OUTER_RD:
            begin
                cmd.mode    = MODE_OUTER;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = outer_reg[IDX_W-1:0];
            end
            S_INNER_SCAN:
            begin
                cmd.mode  = MODE_INNER;
                cmd.rd_en = !scan_end;
            end
            S_EMIT_PEND:
            begin
                cmd.push      = st.out_free;
                cmd.push_pend = 1'b1;
                cmd.push_last = 1'b0;
            end
            S_TRADE:
                cmd.trade = 1'b1;
            S_WB_BID:
                cmd.wb_bid = 1'b1;
            S_WB_ASK:
                cmd.wb_ask = 1'b1;
            S_EMIT_FINAL:
            begin
                cmd.push      = st.out_free;
                cmd.push_pend = fin_pend_reg;
                cmd.push_last = 1'b1;
                cmd.push_code = fin_code_reg;
            end
            default:
                cmd.load = 1'b0;
        endcase
    end

endmodule

>>> rtl/lobm_dp.sv
// Datapath of the order book matcher: slot memory, valid bits, scan
// evaluation, trade arithmetic and result register. Depends on lobm_pkg.
module lobm_dp
    import lobm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        opcode,
    input  logic        side,
    input  logic [31:0] order_id,
    input  logic [15:0] instrument,
    input  logic [31:0] market_code,
    input  logic [23:0] currency_code,
    input  logic [19:0] limit_price,
    input  logic [23:0] order_quantity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] trade_id,
    output logic [31:0] buy_order_id,
    output logic [31:0] sell_order_id,
    output logic [31:0] trade_market,
    output logic [23:0] trade_currency,
    output logic [19:0] trade_price,
    output logic [23:0] trade_quantity,
    output logic        last
);

    slot_t slot_mem [BOOK_DEPTH];
    slot_t rdata_reg;

    logic [BOOK_DEPTH-1:0] valid_reg;
    logic [31:0]           arr_cnt_reg;
    logic [31:0]           trade_cnt_reg;

    // latched input transaction
    logic        in_op_reg, in_side_reg;
    logic [31:0] in_oid_reg, in_mkt_reg;
    logic [15:0] in_instr_reg;
    logic [23:0] in_cur_reg, in_qty_reg;
    logic [19:0] in_price_reg;

    logic  ev_vld_reg;
    idx_t  ev_idx_reg;
    mode_t ev_mode_reg;

    logic        bid_found_reg, ask_found_reg;
    logic [19:0] bp_reg, ap_reg;

    logic        pick_found_reg;
    idx_t        pick_idx_reg;
    logic [19:0] pick_price_reg;
    logic [31:0] pick_age_reg;

    slot_t       hold_rec_reg;
    idx_t        hold_idx_reg;
    logic [31:0] hold_age_reg;

    logic        pair_found_reg;
    slot_t       pb_rec_reg, pa_rec_reg;
    idx_t        pb_idx_reg, pa_idx_reg;
    logic [31:0] pb_age_reg, pa_age_reg;

    logic        pend_vld_reg;
    logic [31:0] pend_tid_reg, pend_boid_reg, pend_soid_reg, pend_mkt_reg;
    logic [23:0] pend_cur_reg, pend_qty_reg;
    logic [19:0] pend_price_reg;

    logic        out_vld_reg;
    status_t     out_status_reg;
    logic [31:0] out_tid_reg, out_boid_reg, out_soid_reg, out_mkt_reg;
    logic [23:0] out_cur_reg, out_qty_reg;
    logic [19:0] out_price_reg;
    logic        out_last_reg;

    idx_t        free_idx;
    logic        ev_is;
    logic [31:0] ev_age;
    logic        bid_take, ask_take, can_hit, pick_better, pick_take;
    logic        hold_take, hold_hit, ask_hit, pair_take;
    logic [23:0] trade_q;
    logic        wr_en;
    idx_t        wr_addr;
    slot_t       wr_data;
    slot_t       new_rec;
    logic        out_free;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = idx_t'(i);
        end
    end

    assign new_rec = '{side: in_side_reg, price: in_price_reg, qty: in_qty_reg,
                       oid: in_oid_reg, instr: in_instr_reg, mkt: in_mkt_reg,
                       cur: in_cur_reg, arrival: arr_cnt_reg};

    always_comb
    begin
        wr_en   = cmd.insert | cmd.wb_bid | cmd.wb_ask;
        wr_addr = free_idx;
        wr_data = new_rec;
        if (cmd.wb_bid)
        begin
            wr_addr = pb_idx_reg;
            wr_data = pb_rec_reg;
        end
        else if (cmd.wb_ask)
        begin
            wr_addr = pa_idx_reg;
            wr_data = pa_rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rdata_reg <= slot_mem[cmd.rd_addr];
    end

    // scan evaluation on the registered read data
    assign ev_is  = ev_vld_reg && valid_reg[ev_idx_reg];
    assign ev_age = arr_cnt_reg - rdata_reg.arrival;

    assign bid_take = ev_is && (ev_mode_reg == MODE_BEST) && (rdata_reg.side == SIDE_BID)
                      && (!bid_found_reg || rdata_reg.price > bp_reg);
    assign ask_take = ev_is && (ev_mode_reg == MODE_BEST) && (rdata_reg.side == SIDE_ASK)
                      && (!ask_found_reg || rdata_reg.price < ap_reg);

    assign can_hit = ev_is && (ev_mode_reg == MODE_CANCEL)
                     && (rdata_reg.side == in_side_reg) && (rdata_reg.oid == in_oid_reg)
                     && (rdata_reg.mkt == in_mkt_reg) && (rdata_reg.cur == in_cur_reg);
    assign pick_better = (in_side_reg == SIDE_BID) ? (rdata_reg.price > pick_price_reg)
                                                   : (rdata_reg.price < pick_price_reg);
    assign pick_take = can_hit && (!pick_found_reg || pick_better
                       || (rdata_reg.price == pick_price_reg && ev_age > pick_age_reg));

    assign hold_take = ev_vld_reg && (ev_mode_reg == MODE_OUTER);
    // bid at the best level, seen in the same cycle the controller decides
    assign hold_hit  = hold_take && ev_is && (rdata_reg.side == SIDE_BID)
                       && (rdata_reg.price == bp_reg);

    assign ask_hit = ev_is && (ev_mode_reg == MODE_INNER) && (rdata_reg.side == SIDE_ASK)
                     && (rdata_reg.price == ap_reg) && (rdata_reg.instr == hold_rec_reg.instr)
                     && (rdata_reg.mkt == hold_rec_reg.mkt)
                     && (rdata_reg.cur == hold_rec_reg.cur);
    // older bid wins, then older ask of the same bid
    assign pair_take = ask_hit && (!pair_found_reg || hold_age_reg > pb_age_reg
                       || (hold_idx_reg == pb_idx_reg && ev_age > pa_age_reg));

    assign trade_q  = (pb_rec_reg.qty < pa_rec_reg.qty) ? pb_rec_reg.qty : pa_rec_reg.qty;
    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            arr_cnt_reg    <= '0;
            trade_cnt_reg  <= 32'd1;
            ev_vld_reg     <= 1'b0;
            bid_found_reg  <= 1'b0;
            ask_found_reg  <= 1'b0;
            pick_found_reg <= 1'b0;
            pair_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            ev_vld_reg <= cmd.rd_en;
            if (cmd.insert)
            begin
                valid_reg[free_idx] <= 1'b1;
                arr_cnt_reg         <= arr_cnt_reg + 32'd1;
            end
            if (cmd.cancel_clr && pick_found_reg)
                valid_reg[pick_idx_reg] <= 1'b0;
            if (cmd.wb_bid && pb_rec_reg.qty == '0)
                valid_reg[pb_idx_reg] <= 1'b0;
            if (cmd.wb_ask && pa_rec_reg.qty == '0)
                valid_reg[pa_idx_reg] <= 1'b0;

            if (cmd.clr_best)
            begin
                bid_found_reg <= 1'b0;
                ask_found_reg <= 1'b0;
            end
            else
            begin
                if (bid_take)
                    bid_found_reg <= 1'b1;
                if (ask_take)
                    ask_found_reg <= 1'b1;
            end

            if (cmd.clr_pick)
                pick_found_reg <= 1'b0;
            else if (pick_take)
                pick_found_reg <= 1'b1;

            if (cmd.clr_pair)
                pair_found_reg <= 1'b0;
            else if (pair_take)
                pair_found_reg <= 1'b1;

            if (cmd.trade)
            begin
                pend_vld_reg  <= 1'b1;
                trade_cnt_reg <= trade_cnt_reg + 32'd1;
            end
            else if (cmd.push && cmd.push_pend)
                pend_vld_reg <= 1'b0;

            if (cmd.push)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_idx_reg  <= cmd.rd_addr;
        ev_mode_reg <= cmd.mode;
        if (cmd.load)
        begin
            in_op_reg    <= opcode;
            in_side_reg  <= side;
            in_oid_reg   <= order_id;
            in_instr_reg <= instrument;
            in_mkt_reg   <= market_code;
            in_cur_reg   <= currency_code;
            in_price_reg <= limit_price;
            in_qty_reg   <= order_quantity;
        end
        if (bid_take)
            bp_reg <= rdata_reg.price;
        if (ask_take)
            ap_reg <= rdata_reg.price;
        if (pick_take)
        begin
            pick_idx_reg   <= ev_idx_reg;
            pick_price_reg <= rdata_reg.price;
            pick_age_reg   <= ev_age;
        end
        if (hold_take)
        begin
            hold_rec_reg <= rdata_reg;
            hold_idx_reg <= ev_idx_reg;
            hold_age_reg <= ev_age;
        end
        if (pair_take)
        begin
            pb_rec_reg <= hold_rec_reg;
            pb_idx_reg <= hold_idx_reg;
            pb_age_reg <= hold_age_reg;
            pa_rec_reg <= rdata_reg;
            pa_idx_reg <= ev_idx_reg;
            pa_age_reg <= ev_age;
        end
        else if (cmd.trade)
        begin
            pb_rec_reg.qty <= pb_rec_reg.qty - trade_q;
            pa_rec_reg.qty <= pa_rec_reg.qty - trade_q;
        end
        if (cmd.trade)
        begin
            pend_tid_reg   <= trade_cnt_reg;
            pend_boid_reg  <= pb_rec_reg.oid;
            pend_soid_reg  <= pa_rec_reg.oid;
            pend_mkt_reg   <= pb_rec_reg.mkt;
            pend_cur_reg   <= pb_rec_reg.cur;
            pend_price_reg <= pa_rec_reg.price;
            pend_qty_reg   <= trade_q;
        end
        if (cmd.push)
        begin
            out_last_reg <= cmd.push_last;
            if (cmd.push_pend)
            begin
                out_status_reg <= ST_TRADE;
                out_tid_reg    <= pend_tid_reg;
                out_boid_reg   <= pend_boid_reg;
                out_soid_reg   <= pend_soid_reg;
                out_mkt_reg    <= pend_mkt_reg;
                out_cur_reg    <= pend_cur_reg;
                out_price_reg  <= pend_price_reg;
                out_qty_reg    <= pend_qty_reg;
            end
            else
            begin
                out_status_reg <= cmd.push_code;
                out_tid_reg    <= '0;
                out_boid_reg   <= '0;
                out_soid_reg   <= '0;
                out_mkt_reg    <= '0;
                out_cur_reg    <= '0;
                out_price_reg  <= '0;
                out_qty_reg    <= '0;
            end
        end
    end

    always_comb
    begin
        st.opcode     = in_op_reg;
        st.qty_zero   = (in_qty_reg == '0);
        st.full       = &valid_reg;
        st.pick_found = pick_found_reg;
        st.best_ok    = bid_found_reg && ask_found_reg && (bp_reg >= ap_reg);
        st.hold_cand  = hold_hit;
        st.pair_found = pair_found_reg;
        st.pend_vld   = pend_vld_reg;
        st.out_free   = out_free;
    end

    assign out_valid      = out_vld_reg;
    assign status         = out_status_reg;
    assign trade_id       = out_tid_reg;
    assign buy_order_id   = out_boid_reg;
    assign sell_order_id  = out_soid_reg;
    assign trade_market   = out_mkt_reg;
    assign trade_currency = out_cur_reg;
    assign trade_price    = out_price_reg;
    assign trade_quantity = out_qty_reg;
    assign last           = out_last_reg;

endmodule

>>> rtl/lobm_checker.sv
// Port-level checks of the order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
    import lobm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [31:0] trade_id,
    input logic [23:0] trade_quantity,
    input logic        last
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // busy straight after taking a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    // any non-trade status is marked as the last result of its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_TRADE |-> last)
        else $error("non-trade result not marked last");

    // non-trade results carry a zero trade id and trade quantity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_TRADE |-> trade_id == '0 && trade_quantity == '0)
        else $error("trade data on a non-trade result");

    // a trade always moves some quantity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_TRADE |-> trade_quantity != '0)
        else $error("zero-quantity trade");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (.*);
